@@ hw/rtl/box_mean_filter_3x3_5x5_unit_macros.svh @@
// Assertion macros used by the checker file of the box mean filter.
// No dependencies; the including file supplies clk and arst_n in scope.
`ifndef BOX_MEAN_FILTER_3X3_5X5_UNIT_MACROS_SVH
`define BOX_MEAN_FILTER_3X3_5X5_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication that is checked during reset as well.
`define BMF_ASSERT_ALWAYS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/bmf_pkg.sv @@
// Shared types and constants of the box mean filter.
// No dependencies; imported by the top level, bmf_window and bmf_divide.
`default_nettype none

package bmf_pkg;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 11;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_MODE = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH  = 1'b1;

	localparam logic                     MODE_3X3        = 1'b0;
	localparam logic                     MODE_5X5        = 1'b1;
	localparam logic [CFG_DATA_BITS-1:0] LINE_WIDTH_RST  = 11'd1024;
	localparam logic [CFG_DATA_BITS-1:0] LINE_WIDTH_MIN  = 11'd5;

	// Row counter saturates once four full lines sit in the line store.
	localparam int                ROW_BITS = 3;
	localparam logic [ROW_BITS-1:0] ROW_SAT = 3'd4;

	// Rounding offsets: half of the divisor, rounded down.
	localparam int ROUND_3X3 = 4;
	localparam int ROUND_5X5 = 12;
	localparam int DIV_3X3   = 9;
	localparam int DIV_5X5   = 25;

	// Control that travels alongside an item through the pipeline.
	typedef struct packed {
		logic frame_start;
		logic mode5;
		logic row_end;
		logic emit;
	} bmf_tag_t;

endpackage

`default_nettype wire

@@ hw/rtl/bmf_line_mem.sv @@
// Line store: one word per column holding the four previous lines.
// Simple dual-port RAM with a registered read; no dependencies.
`default_nettype none

module bmf_line_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bmf_window.sv @@
// Vertical column sum, column-sum history and window sum (stage one to two).
// Depends on bmf_pkg for the item tag.
`default_nettype none

module bmf_window
	import bmf_pkg::*;
#(
	parameter int PIXEL_BITS = 8
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         fire,
	input  wire  [PIXEL_BITS-1:0]       pix,
	input  wire  [4*PIXEL_BITS-1:0]     lines,
	input  bmf_tag_t                    tag,
	output logic [4*PIXEL_BITS-1:0]     wr_word,
	output logic [PIXEL_BITS+4:0]       hsum_s2,
	output bmf_tag_t                    tag_s2
);

	localparam int VW = PIXEL_BITS + 3;
	localparam int HW = PIXEL_BITS + 5;

	logic [VW-1:0] cs_q   [4];
	logic [VW-1:0] cs_old [4];
	logic [VW-1:0] vsum;
	logic [HW-1:0] hsum;
	logic [PIXEL_BITS-1:0] ln [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ln[i]     = lines[i*PIXEL_BITS +: PIXEL_BITS];
			cs_old[i] = tag.frame_start ? '0 : cs_q[i];
		end
		vsum = VW'(pix) + VW'(ln[0]) + VW'(ln[1]);
		if (tag.mode5) begin
			vsum = vsum + VW'(ln[2]) + VW'(ln[3]);
		end
		hsum = HW'(vsum) + HW'(cs_old[0]) + HW'(cs_old[1]);
		if (tag.mode5) begin
			hsum = hsum + HW'(cs_old[2]) + HW'(cs_old[3]);
		end
	end

	// Each stored line but the oldest moves one line down, the oldest is dropped, and the new pixel becomes line zero.
	assign wr_word = {lines[3*PIXEL_BITS-1:0], pix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				cs_q[i] <= '0;
			end
		end else if (fire) begin
			cs_q[0] <= vsum;
			for (int i = 1; i < 4; i++) begin
				cs_q[i] <= cs_old[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hsum_s2 <= hsum;
			tag_s2  <= tag;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bmf_divide.sv @@
// Rounded division of the window sum by 9 or 25 (stage three and output).
// Reciprocal multiply, then one compare and correct; depends on bmf_pkg.
`default_nettype none

module bmf_divide
	import bmf_pkg::*;
#(
	parameter int PIXEL_BITS = 8
) (
	input  wire                    clk,
	input  wire                    en_s3,
	input  wire                    en_out,
	input  wire  [PIXEL_BITS+4:0]  hsum_s2,
	input  bmf_tag_t               tag_s2,
	output logic [PIXEL_BITS-1:0]  mean_q,
	output logic                   last_q
);

	localparam int NW = PIXEL_BITS + 5;
	localparam int unsigned RECIP9  = (32'd1 << NW) / DIV_3X3;
	localparam int unsigned RECIP25 = (32'd1 << NW) / DIV_5X5;
	localparam logic [NW-1:0] PMAX = NW'((32'd1 << PIXEL_BITS) - 32'd1);

	logic [NW-1:0]   num;
	logic [NW-1:0]   n_s3;
	logic [2*NW-1:0] prod_s3;
	bmf_tag_t        tag_s3;
	logic [NW-1:0]   q0, qd, rem, q;
	logic [NW-1:0]   dv;

	assign num = tag_s2.mode5 ? hsum_s2 + NW'(ROUND_5X5) : hsum_s2 + NW'(ROUND_3X3);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			n_s3    <= num;
			prod_s3 <= (2*NW)'(num) * (2*NW)'(tag_s2.mode5 ? RECIP25 : RECIP9);
			tag_s3  <= tag_s2;
		end
	end

	// The truncated reciprocal leaves the quotient at most one too small.
	always_comb begin
		q0 = prod_s3[2*NW-1:NW];
		if (tag_s3.mode5) begin
			qd = (q0 << 4) + (q0 << 3) + q0;
			dv = NW'(DIV_5X5);
		end else begin
			qd = (q0 << 3) + q0;
			dv = NW'(DIV_3X3);
		end
		rem = n_s3 - qd;
		q   = (rem >= dv) ? q0 + NW'(1) : q0;
		// Column sums left over from a mode change can push the mean past full scale.
		if (q > PMAX) begin
			q = PMAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			mean_q <= q[PIXEL_BITS-1:0];
			last_q <= tag_s3.row_end;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/box_mean_filter_3x3_5x5_unit.sv @@
// Box mean filter over a 3x3 or 5x5 window: top level with counters and handshake.
// Depends on bmf_pkg, bmf_line_mem, bmf_window and bmf_divide.
//
// Usage. Pixels enter in raster order on the s_ channel, one item per pixel, border
// included; s_tuser set marks the first pixel of a frame and clears the row and
// column position and the column sums. Once K-1 full lines and K columns of the
// current line have arrived (K = 3 or 5 from window_mode), each pixel yields one
// item on the m_ channel: the rounded mean of the KxK window ending at that pixel,
// with m_tlast on the last result of each row. Other pixels yield nothing.
// Throughput is one pixel per cycle while the output is not stalled, set by one read
// and one write of the line store per cycle, each at a single column. A result is
// offered once its pixel has passed the line store read register, the window sum,
// the reciprocal multiply and the output register, in that order.
// Each stage holds its item independently, so s_tready stays high while any bubble
// remains in the pipeline; only when all four stages are full and m_tready is low
// does s_tready fall, and the output item then holds until taken.
// Reset clears the pipeline, counters and column sums and sets a 3x3 window and a
// line width of 1024. The line store needs no clearing. Configuration is to be
// written through cfg_we, cfg_index and cfg_wdata only while idle; not enforced.
`default_nettype none

module box_mean_filter_3x3_5x5_unit
	import bmf_pkg::*;
#(
	parameter int LINE_MAX   = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [((PIXEL_BITS+7)/8)*8-1:0]      s_tdata,   // pixel
	input  wire  [0:0]                           s_tuser,   // frame_start
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [((PIXEL_BITS+7)/8)*8-1:0]      m_tdata,   // mean
	output logic                                 m_tlast,   // row_end
	input  wire                                  cfg_we,
	input  wire  [CFG_INDEX_BITS-1:0]            cfg_index,
	input  wire  [CFG_DATA_BITS-1:0]             cfg_wdata
);

	localparam int DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
	localparam int AW        = $clog2(LINE_MAX);
	localparam int WW        = (AW + 1 > CFG_DATA_BITS) ? AW + 1 : CFG_DATA_BITS;
	localparam int LW        = 4 * PIXEL_BITS;

	// Configuration registers.
	logic                     window_mode_q;
	logic [CFG_DATA_BITS-1:0] line_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_mode_q <= MODE_3X3;
			line_width_q  <= LINE_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_MODE: window_mode_q <= cfg_wdata[0];
				REG_LINE_WIDTH:  line_width_q  <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// Last column index from the clamped line width.
	logic [WW-1:0] lw_ext;
	logic [AW-1:0] w_last;

	always_comb begin
		lw_ext = WW'(line_width_q);
		if (lw_ext < WW'(LINE_WIDTH_MIN)) begin
			w_last = AW'(LINE_WIDTH_MIN - 11'd1);
		end else if (lw_ext > WW'(LINE_MAX)) begin
			w_last = AW'(LINE_MAX - 1);
		end else begin
			w_last = AW'(lw_ext - WW'(1));
		end
	end

	// Handshake chain.
	logic v1_q, v2_q, v3_q, vo_q;
	logic ready2, ready3, ready_o;
	logic accept, fire1, en_s3, en_out;

	assign ready_o  = !vo_q || m_tready;
	assign ready3   = !v3_q || ready_o;
	assign ready2   = !v2_q || ready3;
	assign s_tready = !v1_q || ready2;
	assign accept   = s_tvalid && s_tready;
	assign fire1    = v1_q && ready2;
	assign en_s3    = v2_q && ready3;
	assign en_out   = v3_q && ready_o;

	// Position of the incoming pixel.
	logic [AW-1:0]       column_count_q;
	logic [ROW_BITS-1:0] row_count_q;
	logic [AW-1:0]       col_base, c0;
	logic [ROW_BITS-1:0] row_base;
	logic                fs0;
	logic [AW-1:0]       kmin;
	bmf_tag_t            tag0;

	always_comb begin
		fs0      = s_tuser[0];
		col_base = fs0 ? '0 : column_count_q;
		row_base = fs0 ? '0 : row_count_q;
		// A count beyond a narrowed line width ends the line at its last column.
		c0       = (col_base > w_last) ? w_last : col_base;
		kmin     = (window_mode_q == MODE_5X5) ? AW'(4) : AW'(2);
		tag0.frame_start = fs0;
		tag0.mode5       = (window_mode_q == MODE_5X5);
		tag0.row_end     = (c0 == w_last);
		tag0.emit        = (ROW_BITS'(kmin) <= row_base) && (c0 >= kmin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (accept) begin
			if (tag0.row_end) begin
				column_count_q <= '0;
				row_count_q    <= (row_base < ROW_SAT) ? row_base + ROW_BITS'(1) : row_base;
			end else begin
				column_count_q <= c0 + AW'(1);
				row_count_q    <= row_base;
			end
		end
	end

	// Stage one: line store read, with bypass of a write to the same column.
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [AW-1:0]         c_s1;
	bmf_tag_t              tag_s1;
	logic                  fwd_s1;
	logic [LW-1:0]         fwd_word_s1;
	logic [LW-1:0]         rd_s1;
	logic [LW-1:0]         line_s1;
	logic [LW-1:0]         wr_word;

	bmf_line_mem #(
		.DEPTH (LINE_MAX),
		.WIDTH (LW)
	) u_line_mem (
		.clk     (clk),
		.we      (fire1),
		.waddr   (c_s1),
		.wdata   (wr_word),
		.re      (accept),
		.raddr   (c0),
		.rdata_q (rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (accept) begin
			fwd_s1 <= fire1 && (c0 == c_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= s_tdata[PIXEL_BITS-1:0];
			c_s1        <= c0;
			tag_s1      <= tag0;
			fwd_word_s1 <= wr_word;
		end
	end

	assign line_s1 = fwd_s1 ? fwd_word_s1 : rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (s_tready) v1_q <= s_tvalid;
			// Items outside a full window leave the pipeline after stage one.
			if (ready2)   v2_q <= v1_q && tag_s1.emit;
			if (ready3)   v3_q <= v2_q;
			if (ready_o)  vo_q <= v3_q;
		end
	end

	// Stage two: sums.
	logic [PIXEL_BITS+4:0] hsum_s2;
	bmf_tag_t              tag_s2;

	bmf_window #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire1),
		.pix     (pix_s1),
		.lines   (line_s1),
		.tag     (tag_s1),
		.wr_word (wr_word),
		.hsum_s2 (hsum_s2),
		.tag_s2  (tag_s2)
	);

	// Stage three and output register: division.
	logic [PIXEL_BITS-1:0] mean_q;
	logic                  last_q;

	bmf_divide #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_divide (
		.clk     (clk),
		.en_s3   (en_s3),
		.en_out  (en_out),
		.hsum_s2 (hsum_s2),
		.tag_s2  (tag_s2),
		.mean_q  (mean_q),
		.last_q  (last_q)
	);

	assign m_tvalid = vo_q;
	assign m_tdata  = DATA_BITS'(mean_q);
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/bmf_checker.sv @@
// Port-level checks of the box mean filter, bound to its top level.
// Depends on box_mean_filter_3x3_5x5_unit_macros.svh for the assertion macros.
`default_nettype none

`include "box_mean_filter_3x3_5x5_unit_macros.svh"

module bmf_checker #(
	parameter int PIXEL_BITS = 8
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_tready,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [((PIXEL_BITS+7)/8)*8-1:0]   m_tdata,
	input wire                              m_tlast
);

	// No result may be offered while reset is applied.
	`BMF_ASSERT_ALWAYS(a_reset_quiet, !arst_n, !m_tvalid, "result offered during reset")

	// A stalled result keeps its value until it is taken.
	`BMF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

	// The input side only stalls when the whole pipeline is backed up behind the output.
	`BMF_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready,
		"input stalled without a stalled result")

endmodule

bind box_mean_filter_3x3_5x5_unit bmf_checker #(.PIXEL_BITS(PIXEL_BITS)) u_bmf_checker (.*);

`default_nettype wire
